// ===== rtl/core/xrg_pkg.sv =====
// shared types, constants and generator step functions for the xoshiro range generator
// no dependencies; imported by every module of the block
package xrg_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int MID_W   = HALF_W + 2;
    localparam int NWORDS  = 4;
    localparam int SHIFT_A = 17;
    localparam int ROT_B   = 45;
    localparam int SEED_STEPS = 4;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [2*HALF_W-1:0] t_prod;
    typedef logic [NWORDS-1:0][WORD_W-1:0] t_gen;

    localparam t_gen SEED_MASK = {
        64'hFFFF_0000_0000_0000,
        64'h0000_FFFF_0000_0000,
        64'h0000_0000_FFFF_0000,
        64'h0000_0000_0000_FFFF
    };

    typedef enum logic {
        OP_RESEED = 1'b0,
        OP_DRAW   = 1'b1
    } t_op;

    // sum and span of one draw, plus its lower bound
    typedef struct packed {
        t_word sum;
        t_word span;
        t_word lo;
    } t_sum_stage;

    // four 32x32 partial products of sum times span
    typedef struct packed {
        t_prod ll;
        t_prod lh;
        t_prod hl;
        t_prod hh;
        t_word lo;
    } t_prod_stage;

    // high partial sum and carry out of the middle column
    typedef struct packed {
        t_word              hsum;
        logic [MID_W-HALF_W-1:0] carry;
        t_word              lo;
    } t_acc_stage;

    function automatic t_word rotl(input t_word x);
        rotl = (x << ROT_B) | (x >> (WORD_W - ROT_B));
    endfunction

    function automatic t_gen gen_advance(input t_gen g);
        t_gen  s;
        t_word t;
        s = g;
        t = s[1] << SHIFT_A;
        s[2] = s[2] ^ s[0];
        s[3] = s[3] ^ s[1];
        s[1] = s[1] ^ s[2];
        s[0] = s[0] ^ s[3];
        s[2] = s[2] ^ t;
        s[3] = rotl(s[3]);
        gen_advance = s;
    endfunction

    // masked seed slices, then the discarded warm-up steps
    function automatic t_gen seed_load(input t_word seed);
        t_gen s;
        for (int i = 0; i < NWORDS; i++) begin
            s[i] = seed & SEED_MASK[i];
        end
        for (int k = 0; k < SEED_STEPS; k++) begin
            s = gen_advance(s);
        end
        seed_load = s;
    endfunction

endpackage

// ===== rtl/core/xrg_gen.sv =====
// generator state words and first pipeline stage (sum and span of a draw)
// depends on xrg_pkg
module xrg_gen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  xrg_pkg::t_word     i_seed,
    input  xrg_pkg::t_word     i_lo,
    input  xrg_pkg::t_word     i_hi,
    output logic               o_valid,
    input  logic               i_ready,
    output xrg_pkg::t_sum_stage o_data
);
    import xrg_pkg::*;

    t_gen       r_gen, n_gen;
    logic       r_valid, n_valid;
    t_sum_stage r_data;
    logic       accept;
    logic       is_draw;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign is_draw = (t_op'(i_op) == OP_DRAW);

    always_comb begin
        n_gen   = r_gen;
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = accept && is_draw;
        end
        if (accept) begin
            if (is_draw) begin
                n_gen = gen_advance(r_gen);
            end else begin
                n_gen = seed_load(i_seed);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_gen   <= n_gen;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_draw) begin
            r_data.sum  <= r_gen[0] + r_gen[3];
            r_data.span <= i_hi - i_lo;
            r_data.lo   <= i_lo;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/xrg_mul.sv =====
// partial product stage: four registered 32x32 multiplies of sum and span
// depends on xrg_pkg
module xrg_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  xrg_pkg::t_sum_stage  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output xrg_pkg::t_prod_stage o_data
);
    import xrg_pkg::*;

    logic        r_valid;
    t_prod_stage r_data;
    logic [HALF_W-1:0] a_lo, a_hi, b_lo, b_hi;

    assign o_ready = !r_valid || i_ready;
    assign a_lo = i_data.sum[HALF_W-1:0];
    assign a_hi = i_data.sum[WORD_W-1:HALF_W];
    assign b_lo = i_data.span[HALF_W-1:0];
    assign b_hi = i_data.span[WORD_W-1:HALF_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data.ll <= t_prod'(a_lo) * t_prod'(b_lo);
            r_data.lh <= t_prod'(a_lo) * t_prod'(b_hi);
            r_data.hl <= t_prod'(a_hi) * t_prod'(b_lo);
            r_data.hh <= t_prod'(a_hi) * t_prod'(b_hi);
            r_data.lo <= i_data.lo;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/xrg_acc.sv =====
// product accumulation: middle-column carry and high sum, then the final add of the bound
// depends on xrg_pkg
module xrg_acc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  xrg_pkg::t_prod_stage i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output xrg_pkg::t_word       o_value
);
    import xrg_pkg::*;

    logic       r_acc_valid, r_out_valid;
    t_acc_stage r_acc;
    t_word      r_value;
    logic       acc_ready;
    logic [MID_W-1:0] mid;

    assign acc_ready = !r_out_valid || i_ready;
    assign o_ready   = !r_acc_valid || acc_ready;

    assign mid = MID_W'(i_data.ll[2*HALF_W-1:HALF_W])
               + MID_W'(i_data.lh[HALF_W-1:0])
               + MID_W'(i_data.hl[HALF_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_acc_valid <= i_valid;
            end
            if (acc_ready) begin
                r_out_valid <= r_acc_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_acc.hsum  <= i_data.hh
                         + WORD_W'(i_data.lh[2*HALF_W-1:HALF_W])
                         + WORD_W'(i_data.hl[2*HALF_W-1:HALF_W]);
            r_acc.carry <= mid[MID_W-1:HALF_W];
            r_acc.lo    <= i_data.lo;
        end
        if (acc_ready && r_acc_valid) begin
            r_value <= r_acc.hsum + WORD_W'(r_acc.carry) + r_acc.lo;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_value;

endmodule

// ===== rtl/core/xoshiro_range_generator.sv =====
// xoshiro256+ source scaled into [min, max): a draw beat passes the sum, product, accumulate
// and output registers to the master side; throughput one beat per cycle, back to back,
// while results are taken; reseed beats give no result and set the state in the cycle they are accepted
// each stage holds its own valid bit, so bubbles collapse while a result waits
// reset (synchronous, active low) clears the four generator words to zero and
// empties the pipeline; draws before any reseed return range_min
module xoshiro_range_generator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // slave side: one beat is a reseed or a draw
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata fields from bit 0: seed[63:0], range_min[127:64], range_max[191:128]
    input  logic [191:0]  s_axis_tdata,
    // tuser fields from bit 0: op (0 reseed, 1 draw)
    input  logic          s_axis_tuser,
    // master side: one beat per draw
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata fields from bit 0: value[63:0]
    output logic [63:0]   m_axis_tdata
);
    import xrg_pkg::*;

    // stage 1: state words step on each accepted draw, sum and span are registered
    logic        sum_valid, sum_ready;
    t_sum_stage  sum_data;
    // stage 2: partial products
    logic        prod_valid, prod_ready;
    t_prod_stage prod_data;

    xrg_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_seed  (s_axis_tdata[WORD_W-1:0]),
        .i_lo    (s_axis_tdata[2*WORD_W-1:WORD_W]),
        .i_hi    (s_axis_tdata[3*WORD_W-1:2*WORD_W]),
        .o_valid (sum_valid),
        .i_ready (sum_ready),
        .o_data  (sum_data)
    );

    xrg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .o_ready (sum_ready),
        .i_data  (sum_data),
        .o_valid (prod_valid),
        .i_ready (prod_ready),
        .o_data  (prod_data)
    );

    // stages 3 and 4: high half of the product, then the lower bound is added
    xrg_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .o_ready (prod_ready),
        .i_data  (prod_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_value (m_axis_tdata)
    );

endmodule
